FILE: rtl/table_driven_pushdown_recognizer_defines.svh
// Assertion macros for the pushdown recognizer.
`ifndef TABLE_DRIVEN_PUSHDOWN_RECOGNIZER_DEFINES_SVH
`define TABLE_DRIVEN_PUSHDOWN_RECOGNIZER_DEFINES_SVH

// condition holds at every clock edge out of reset
`define TDPR_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// antecedent at one edge implies consequent at the next
`define TDPR_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/tdpr_pkg.sv
// Shared types and codes for the pushdown recognizer.
`timescale 1ns / 1ps
package tdpr_pkg;

  localparam int ACT_W = 22;  // target, push length, push first, push second

  typedef enum logic [1:0] {
    ACT_WRITE  = 2'd0,
    ACT_SYMBOL = 2'd1,
    ACT_END    = 2'd2
  } action_t;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_EMPTY      = 4'd1,
    ST_NO_TRANS   = 4'd2,
    ST_OVERFLOW   = 4'd3,
    ST_EPS_LIMIT  = 4'd4,
    ST_ACC_BOTH   = 4'd5,
    ST_ACC_FINAL  = 4'd6,
    ST_ACC_EMPTY  = 4'd7,
    ST_REJECT_END = 4'd8,
    ST_WRITTEN    = 4'd9
  } status_t;

  typedef enum logic [1:0] {
    REG_BOTTOM = 2'd0,
    REG_START  = 2'd1,
    REG_ACCEPT = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] st;
    logic       eps;
    logic [7:0] sym;
    logic [7:0] top;
  } key_t;

  typedef struct packed {
    logic [3:0] state;
    logic       eps;
    logic [7:0] sym;
    logic [7:0] top;
    logic       nonempty;
  } lookup_t;

endpackage

FILE: rtl/table_driven_pushdown_recognizer.sv
// Top level of the table-driven pushdown recognizer.
`timescale 1ns / 1ps
`include "table_driven_pushdown_recognizer_defines.svh"
// One request at a time. A table write, an unused action, a request that
// meets an already rejected run, or a symbol request that meets an empty
// stack goes from the idle state straight to the result state. Any other
// symbol or end request passes through a lookup state, then an apply state
// in which the table action memory returns its data, once per transition
// fired, plus a wait state after a move that pops without pushing onto a
// nonempty stack, while the stack memory returns the new top. A move that
// would overflow ends the request. An end request with no epsilon moves
// goes from the lookup straight to the result state. The top of the stack
// is held in a register; the memory holds the symbols below it. The next
// request is taken while a result still waits on the output.
module table_driven_pushdown_recognizer #(
  parameter int STATE_COUNT   = 16,
  parameter int TABLE_ENTRIES = 32,
  parameter int STACK_DEPTH   = 64,
  parameter int MAX_PUSH      = 2,
  parameter int EPSILON_LIMIT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [4:0]  slot_index,
  input  logic        slot_valid,
  input  logic [3:0]  key_state,
  input  logic        key_is_epsilon,
  input  logic [7:0]  in_symbol,
  input  logic [7:0]  key_top,
  input  logic [3:0]  target_state,
  input  logic [1:0]  push_length,
  input  logic [7:0]  push_first,
  input  logic [7:0]  push_second,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  status,
  output logic [3:0]  current_state,
  output logic [6:0]  stack_depth,
  output logic        string_done,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TW = $clog2(TABLE_ENTRIES);
  localparam int SW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(STACK_DEPTH + 1);
  localparam int CW = $clog2(EPSILON_LIMIT + 1);
  localparam int SLW = (TW > 5) ? TW : 5;
  localparam int PUSH_LIM = (MAX_PUSH < 2) ? MAX_PUSH : 2;

  typedef enum logic [4:0] {
    S_IDLE    = 5'b00001,
    S_LOOK    = 5'b00010,
    S_APPLY   = 5'b00100,
    S_STKWAIT = 5'b01000,
    S_RESULT  = 5'b10000
  } fsm_t;

  function automatic logic [3:0] mod_state(input logic [3:0] v);
    logic [3:0] r;
    r = v;
    for (int i = 0; i < 8; i++) begin
      if (32'(r) >= STATE_COUNT) begin
        r = r - 4'(STATE_COUNT);
      end
    end
    return r;
  endfunction

  fsm_t              fsm;
  logic [7:0]        bottom_sym;
  logic [3:0]        start_st;
  logic [3:0]        accept_st;
  logic [3:0]        run_state;
  logic [PW-1:0]     sp;
  logic [7:0]        top_sym;
  logic              rejected;
  logic              fresh;
  logic              eps_mode;
  logic [CW-1:0]     eps_cnt;
  logic              is_end;
  logic [7:0]        cur_sym;
  tdpr_pkg::status_t res_status;

  logic                    accept;
  logic                    cfg_we;
  logic [SLW-1:0]          slot_ext;
  logic                    slot_ok;
  logic                    tbl_we;
  tdpr_pkg::key_t          wkey;
  tdpr_pkg::lookup_t       req;
  logic                    hit;
  logic [TW-1:0]           hit_idx;
  logic [tdpr_pkg::ACT_W-1:0] tbl_wdata;
  logic [tdpr_pkg::ACT_W-1:0] tbl_rdata;
  logic [3:0]              act_target;
  logic [1:0]              act_plen;
  logic [1:0]              act_len;
  logic [7:0]              act_p1;
  logic [7:0]              act_p2;
  logic [PW:0]             grown;
  logic                    ovf;
  logic [PW-1:0]           new_sp;
  logic [PW-1:0]           sp_m1;
  logic [PW-1:0]           nsp_m1;
  logic                    stk_we;
  logic [7:0]              stk_rdata;
  tdpr_pkg::status_t       end_verdict;

  assign in_stall = (fsm != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      tdpr_pkg::REG_BOTTOM: prdata = {24'd0, bottom_sym};
      tdpr_pkg::REG_START:  prdata = {28'd0, start_st};
      tdpr_pkg::REG_ACCEPT: prdata = {28'd0, accept_st};
      default:              prdata = '0;
    endcase
  end

  // table write
  assign slot_ext = SLW'(slot_index);
  assign slot_ok = (32'(slot_ext) < TABLE_ENTRIES);
  assign tbl_we = accept && (action == tdpr_pkg::ACT_WRITE) && slot_ok;
  assign wkey = '{valid: slot_valid, st: key_state, eps: key_is_epsilon,
                  sym: in_symbol, top: key_top};
  assign tbl_wdata = {mod_state(target_state), push_length, push_first, push_second};

  assign req = '{state: run_state, eps: eps_mode, sym: cur_sym, top: top_sym,
                 nonempty: (sp != '0)};

  tdpr_keys #(.ENTRIES(TABLE_ENTRIES)) u_keys (
    .clk   (clk),
    .rst   (rst),
    .we    (tbl_we),
    .waddr (slot_ext[TW-1:0]),
    .wkey  (wkey),
    .req   (req),
    .hit   (hit),
    .idx   (hit_idx)
  );

  tdpr_ram #(.WIDTH(tdpr_pkg::ACT_W), .DEPTH(TABLE_ENTRIES)) u_tbl_ram (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (slot_ext[TW-1:0]),
    .wdata (tbl_wdata),
    .raddr (hit_idx),
    .rdata (tbl_rdata)
  );

  // transition apply
  assign act_target = tbl_rdata[21:18];
  assign act_plen = tbl_rdata[17:16];
  assign act_p1 = tbl_rdata[15:8];
  assign act_p2 = tbl_rdata[7:0];
  assign act_len = (32'(act_plen) > PUSH_LIM) ? 2'(PUSH_LIM) : act_plen;
  assign grown = (PW+1)'(sp) + (PW+1)'(act_len) - (PW+1)'(1);
  assign ovf = grown > (PW+1)'(STACK_DEPTH);
  assign new_sp = grown[PW-1:0];
  assign sp_m1 = sp - PW'(1);
  assign nsp_m1 = new_sp - PW'(1);
  assign stk_we = (fsm == S_APPLY) && !ovf && (act_len == 2'd2);

  tdpr_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (sp_m1[SW-1:0]),
    .wdata (act_p2),
    .raddr (nsp_m1[SW-1:0]),
    .rdata (stk_rdata)
  );

  always_comb begin
    if (run_state == accept_st) begin
      end_verdict = (sp == '0) ? tdpr_pkg::ST_ACC_BOTH : tdpr_pkg::ST_ACC_FINAL;
    end else begin
      end_verdict = (sp == '0) ? tdpr_pkg::ST_ACC_EMPTY : tdpr_pkg::ST_REJECT_END;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fsm           <= S_IDLE;
      bottom_sym    <= 8'd90;
      start_st      <= 4'd0;
      accept_st     <= 4'd2;
      run_state     <= 4'd0;
      sp            <= PW'(1);
      top_sym       <= 8'd90;
      rejected      <= 1'b0;
      fresh         <= 1'b1;
      eps_mode      <= 1'b0;
      eps_cnt       <= '0;
      is_end        <= 1'b0;
      cur_sym       <= '0;
      res_status    <= tdpr_pkg::ST_OK;
      out_valid     <= 1'b0;
      status        <= '0;
      current_state <= '0;
      stack_depth   <= '0;
      string_done   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (paddr[3:2])
          tdpr_pkg::REG_BOTTOM: bottom_sym <= pwdata[7:0];
          tdpr_pkg::REG_START:  start_st <= pwdata[3:0];
          tdpr_pkg::REG_ACCEPT: accept_st <= pwdata[3:0];
          default: ;
        endcase
      end

      if (out_valid && !out_stall && fsm != S_RESULT) begin
        out_valid <= 1'b0;
      end

      case (fsm)
        S_IDLE: begin
          if (accept) begin
            is_end   <= (action == tdpr_pkg::ACT_END);
            eps_mode <= (action == tdpr_pkg::ACT_END);
            eps_cnt  <= '0;
            cur_sym  <= in_symbol;
            case (action)
              tdpr_pkg::ACT_WRITE: begin
                res_status <= tdpr_pkg::ST_WRITTEN;
                fsm        <= S_RESULT;
              end
              tdpr_pkg::ACT_SYMBOL, tdpr_pkg::ACT_END: begin
                if (fresh) begin
                  run_state <= mod_state(start_st);
                  sp        <= PW'(1);
                  top_sym   <= bottom_sym;
                  rejected  <= 1'b0;
                  fresh     <= 1'b0;
                end
                if (action == tdpr_pkg::ACT_END) begin
                  if (!fresh && rejected) begin
                    res_status <= tdpr_pkg::ST_REJECT_END;
                    fsm        <= S_RESULT;
                  end else begin
                    fsm <= S_LOOK;
                  end
                end else if (!fresh && rejected) begin
                  res_status <= tdpr_pkg::ST_NO_TRANS;
                  fsm        <= S_RESULT;
                end else if (!fresh && sp == '0) begin
                  res_status <= tdpr_pkg::ST_EMPTY;
                  rejected   <= 1'b1;
                  fsm        <= S_RESULT;
                end else begin
                  fsm <= S_LOOK;
                end
              end
              default: begin
                res_status <= tdpr_pkg::ST_OK;
                fsm        <= S_RESULT;
              end
            endcase
          end
        end
        S_LOOK: begin
          if (!hit) begin
            if (eps_mode) begin
              res_status <= is_end ? end_verdict : tdpr_pkg::ST_OK;
            end else begin
              res_status <= tdpr_pkg::ST_NO_TRANS;
              rejected   <= 1'b1;
            end
            fsm <= S_RESULT;
          end else if (eps_mode && eps_cnt >= CW'(EPSILON_LIMIT)) begin
            res_status <= tdpr_pkg::ST_EPS_LIMIT;
            rejected   <= 1'b1;
            fsm        <= S_RESULT;
          end else begin
            fsm <= S_APPLY;
          end
        end
        S_APPLY: begin
          if (ovf) begin
            res_status <= tdpr_pkg::ST_OVERFLOW;
            rejected   <= 1'b1;
            fsm        <= S_RESULT;
          end else begin
            sp        <= new_sp;
            run_state <= act_target;
            if (act_len != 2'd0) begin
              top_sym <= act_p1;
            end
            if (eps_mode) begin
              eps_cnt <= eps_cnt + CW'(1);
            end
            eps_mode <= 1'b1;
            fsm <= (act_len == 2'd0 && new_sp != '0) ? S_STKWAIT : S_LOOK;
          end
        end
        S_STKWAIT: begin
          top_sym <= stk_rdata;
          fsm     <= S_LOOK;
        end
        S_RESULT: begin
          if (!out_valid || !out_stall) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            current_state <= fresh ? mod_state(start_st) : run_state;
            stack_depth   <= fresh ? 7'd1 : 7'(sp);
            string_done   <= is_end;
            if (is_end) begin
              fresh    <= 1'b1;
              rejected <= 1'b0;
            end
            fsm <= S_IDLE;
          end
        end
        default: fsm <= S_IDLE;
      endcase
    end
  end

  `TDPR_ASSERT_ALWAYS(a_sp_bound, sp <= PW'(STACK_DEPTH), "stack pointer beyond depth")
  `TDPR_ASSERT_ALWAYS(a_eps_bound, eps_cnt <= CW'(EPSILON_LIMIT), "epsilon count beyond limit")
  `TDPR_ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, fsm != S_IDLE, "request not taken")
  `TDPR_ASSERT_NEXT(a_result_out, fsm == S_RESULT && !(out_valid && out_stall), out_valid, "result lost")

endmodule

FILE: rtl/tdpr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module tdpr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/tdpr_keys.sv
// Transition key store with lowest-slot priority match.
`timescale 1ns / 1ps
module tdpr_keys #(
  parameter int ENTRIES = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       we,
  input  logic [$clog2(ENTRIES)-1:0] waddr,
  input  tdpr_pkg::key_t             wkey,
  input  tdpr_pkg::lookup_t          req,
  output logic                       hit,
  output logic [$clog2(ENTRIES)-1:0] idx
);

  localparam int TW = $clog2(ENTRIES);

  tdpr_pkg::key_t     keys [ENTRIES];
  logic [ENTRIES-1:0] valid;
  logic [ENTRIES-1:0] match;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (we) begin
      valid[waddr] <= wkey.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      keys[waddr] <= wkey;
    end
  end

  always_comb begin
    for (int i = 0; i < ENTRIES; i++) begin
      match[i] = valid[i] && req.nonempty && keys[i].st == req.state &&
                 keys[i].eps == req.eps && keys[i].top == req.top &&
                 (req.eps || keys[i].sym == req.sym);
    end
  end

  always_comb begin
    hit = 1'b0;
    idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit = 1'b1;
        idx = TW'(i);
      end
    end
  end

endmodule

FILE: verif/table_driven_pushdown_recognizer_tb.sv
// Self-checking testbench for the table-driven pushdown recognizer.
`timescale 1ns / 1ps
module table_driven_pushdown_recognizer_tb;
  import tdpr_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int SLOTS = 32;
  localparam int DEPTH = 64;
  localparam int EPS_MAX = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [1:0] action;
    logic [4:0] slot_index;
    logic       slot_valid;
    logic [3:0] key_state;
    logic       key_is_epsilon;
    logic [7:0] in_symbol;
    logic [7:0] key_top;
    logic [3:0] target_state;
    logic [1:0] push_length;
    logic [7:0] push_first;
    logic [7:0] push_second;
  } request_t;

  typedef struct {
    bit       valid;
    bit [3:0] st;
    bit       eps;
    bit [7:0] sym;
    bit [7:0] top;
    bit [3:0] target;
    bit [1:0] plen;
    bit [7:0] p1;
    bit [7:0] p2;
  } rule_t;

  typedef struct {
    status_t  status;
    bit [3:0] state;
    bit [6:0] depth;
    bit       done;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = '0;
  logic [4:0] slot_index = '0;
  logic slot_valid = 1'b0;
  logic [3:0] key_state = '0;
  logic key_is_epsilon = 1'b0;
  logic [7:0] in_symbol = '0;
  logic [7:0] key_top = '0;
  logic [3:0] target_state = '0;
  logic [1:0] push_length = '0;
  logic [7:0] push_first = '0;
  logic [7:0] push_second = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [3:0] status;
  logic [3:0] current_state;
  logic [6:0] stack_depth;
  logic string_done;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  table_driven_pushdown_recognizer uut (.*);

  always #4 clk = ~clk;

  rule_t rules [SLOTS];
  bit [7:0] pda_stack [DEPTH];
  int pda_sp;
  bit [3:0] pda_state;
  bit pda_rejected;
  bit pda_fresh;
  bit [7:0] cfg_bottom = 8'd90;
  bit [3:0] cfg_start = 4'd0;
  bit [3:0] cfg_accept = 4'd2;

  verdict_t pending_verdicts [$];
  int errors = 0;
  int items_sent = 0;
  int cycles = 0;
  int idle_in_pct = 0;
  int idle_out_pct = 0;
  int hold_left = 0;

  task automatic report(string msg);
    $display("mismatch @%0t: %s", $realtime, msg);
    errors++;
  endtask

  // predictor
  function automatic void load_run();
    pda_stack[0] = cfg_bottom;
    pda_sp = 1;
    pda_state = cfg_start;
    pda_rejected = 1'b0;
    pda_fresh = 1'b0;
  endfunction

  function automatic int find_rule(bit eps, bit [7:0] sym);
    if (pda_sp == 0) return -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!rules[i].valid || rules[i].st != pda_state || rules[i].eps != eps) continue;
      if (rules[i].top != pda_stack[pda_sp-1]) continue;
      if (!eps && rules[i].sym != sym) continue;
      return i;
    end
    return -1;
  endfunction

  function automatic status_t apply_rule(int i);
    int len;
    len = (rules[i].plen > 2) ? 2 : int'(rules[i].plen);
    if (pda_sp - 1 + len > DEPTH) return ST_OVERFLOW;
    pda_sp--;
    if (len == 2) pda_stack[pda_sp++] = rules[i].p2;
    if (len >= 1) pda_stack[pda_sp++] = rules[i].p1;
    pda_state = rules[i].target;
    return ST_OK;
  endfunction

  function automatic status_t run_epsilons();
    int moves;
    int idx;
    status_t s;
    moves = 0;
    forever begin
      idx = find_rule(1'b1, 8'd0);
      if (idx < 0) return ST_OK;
      if (moves >= EPS_MAX) return ST_EPS_LIMIT;
      s = apply_rule(idx);
      if (s != ST_OK) return s;
      moves++;
    end
  endfunction

  function automatic verdict_t predict(request_t r);
    verdict_t v;
    int idx;
    v.status = ST_OK;
    v.done = 1'b0;
    if (r.action == ACT_WRITE) begin
      rules[r.slot_index] = '{r.slot_valid, r.key_state, r.key_is_epsilon, r.in_symbol,
                              r.key_top, r.target_state, r.push_length, r.push_first,
                              r.push_second};
      v.status = ST_WRITTEN;
    end else if (r.action == ACT_SYMBOL) begin
      if (pda_fresh) load_run();
      if (pda_rejected) v.status = ST_NO_TRANS;
      else if (pda_sp == 0) v.status = ST_EMPTY;
      else begin
        idx = find_rule(1'b0, r.in_symbol);
        if (idx < 0) v.status = ST_NO_TRANS;
        else begin
          v.status = apply_rule(idx);
          if (v.status == ST_OK) v.status = run_epsilons();
        end
      end
      if (v.status != ST_OK) pda_rejected = 1'b1;
    end else if (r.action == ACT_END) begin
      if (pda_fresh) load_run();
      v.done = 1'b1;
      if (pda_rejected) v.status = ST_REJECT_END;
      else begin
        v.status = run_epsilons();
        if (v.status == ST_OK) begin
          if (pda_state == cfg_accept) v.status = (pda_sp == 0) ? ST_ACC_BOTH : ST_ACC_FINAL;
          else v.status = (pda_sp == 0) ? ST_ACC_EMPTY : ST_REJECT_END;
        end
      end
    end
    v.state = pda_fresh ? cfg_start : pda_state;
    v.depth = pda_fresh ? 7'd1 : pda_sp[6:0];
    if (r.action == ACT_END) begin
      pda_fresh = 1'b1;
      pda_rejected = 1'b0;
    end
    return v;
  endfunction

  // result checker and receiver
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && out_valid && !out_stall) begin
      if (pending_verdicts.size() == 0) report("result with no request outstanding");
      else begin
        v = pending_verdicts.pop_front();
        if (status != v.status)
          report($sformatf("status %0d, want %0d", status, v.status));
        if (current_state != v.state)
          report($sformatf("current_state %0d, want %0d", current_state, v.state));
        if (stack_depth != v.depth)
          report($sformatf("stack_depth %0d, want %0d", stack_depth, v.depth));
        if (string_done != v.done)
          report($sformatf("string_done %0d, want %0d", string_done, v.done));
      end
    end
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < idle_out_pct);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // driving
  task automatic send(request_t r);
    if ($urandom_range(99) < idle_in_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= r.action;
    slot_index <= r.slot_index;
    slot_valid <= r.slot_valid;
    key_state <= r.key_state;
    key_is_epsilon <= r.key_is_epsilon;
    in_symbol <= r.in_symbol;
    key_top <= r.key_top;
    target_state <= r.target_state;
    push_length <= r.push_length;
    push_first <= r.push_first;
    push_second <= r.push_second;
    pending_verdicts.push_back(predict(r));
    items_sent++;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  function automatic request_t random_request(logic [1:0] act);
    request_t r;
    r.action = act;
    r.slot_index = 5'($urandom);
    r.slot_valid = 1'($urandom);
    r.key_state = 4'($urandom);
    r.key_is_epsilon = 1'($urandom);
    r.in_symbol = 8'($urandom);
    r.key_top = 8'($urandom);
    r.target_state = 4'($urandom);
    r.push_length = 2'($urandom);
    r.push_first = 8'($urandom);
    r.push_second = 8'($urandom);
    return r;
  endfunction

  task automatic send_symbol(bit [7:0] sym);
    request_t r;
    r = random_request(ACT_SYMBOL);
    r.in_symbol = sym;
    send(r);
  endtask

  task automatic send_end();
    send(random_request(ACT_END));
  endtask

  task automatic write_rule(bit [4:0] slot, bit vld, bit [3:0] st, bit eps, bit [7:0] sym,
                            bit [7:0] top, bit [3:0] tgt, bit [1:0] plen, bit [7:0] p1,
                            bit [7:0] p2);
    request_t r;
    r = '{ACT_WRITE, slot, vld, st, eps, sym, top, tgt, plen, p1, p2};
    send(r);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(reg_idx_t idx, bit [31:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= 4'(idx) << 2;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_BOTTOM: cfg_bottom = data[7:0];
      REG_START:  cfg_start = data[3:0];
      default:    cfg_accept = data[3:0];
    endcase
  endtask

  function automatic bit [7:0] pick8();
    case ($urandom_range(5))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic reconfigure();
    wait_idle();
    write_register(REG_BOTTOM, {24'($urandom), pick8()});
    write_register(REG_START, {4'($urandom_range(15)), 24'h0,
                               4'($urandom_range(1) ? 15 : $urandom)});
    write_register(REG_ACCEPT, 32'($urandom_range(15)));
  endtask

  // tests
  task automatic test_directed();
    idle_in_pct = 0;
    idle_out_pct = 0;
    send_symbol(8'd0);
    send_symbol(8'd1);
    send_end();
    send_end();
    write_rule(5'd0, 1'b1, 4'd0, 1'b0, 8'd0, 8'd90, 4'd15, 2'd3, 8'd255, 8'd0);
    write_rule(5'd31, 1'b1, 4'd0, 1'b0, 8'd0, 8'd90, 4'd7, 2'd1, 8'd1, 8'd1);
    write_rule(5'd1, 1'b1, 4'd15, 1'b1, 8'd255, 8'd255, 4'd2, 2'd0, 8'd0, 8'd0);
    send_symbol(8'd0);
    send_end();
    send(random_request(ACT_UNUSED));
    write_rule(5'd2, 1'b1, 4'd0, 1'b0, 8'd7, 8'd90, 4'd5, 2'd1, 8'd90, 8'd0);
    write_rule(5'd3, 1'b1, 4'd5, 1'b1, 8'd0, 8'd90, 4'd5, 2'd1, 8'd90, 8'd0);
    send_symbol(8'd7);
    send_end();
    write_rule(5'd4, 1'b1, 4'd0, 1'b0, 8'd9, 8'd90, 4'd3, 2'd0, 8'd0, 8'd0);
    send_symbol(8'd9);
    send_symbol(8'd9);
    send_end();
    send_symbol(8'd9);
    send_end();
    write_rule(5'd0, 1'b0, 4'd0, 1'b0, 8'd0, 8'd90, 4'd15, 2'd3, 8'd255, 8'd0);
    send_symbol(8'd0);
    send_end();
    wait_idle();
    write_register(REG_ACCEPT, 32'd3);
    send_symbol(8'd9);
    send_end();
    wait_idle();
  endtask

  // a^n b^n with acceptance by both final state and empty stack
  task automatic program_balanced(output bit [7:0] sym_a, output bit [7:0] sym_b);
    bit [31:0] used;
    bit [4:0] slot [5];
    bit [3:0] s0;
    bit [3:0] s1;
    used = 0;
    for (int i = 0; i < 5; i++) begin
      do slot[i] = 5'($urandom); while (used[slot[i]]);
      used[slot[i]] = 1'b1;
    end
    sym_a = pick8();
    do sym_b = pick8(); while (sym_b == sym_a);
    s0 = cfg_start;
    s1 = s0 + 4'($urandom_range(1, 15));
    write_rule(slot[0], 1'b1, s0, 1'b0, sym_a, cfg_bottom, s0, 2'd2, sym_a, cfg_bottom);
    write_rule(slot[1], 1'b1, s0, 1'b0, sym_a, sym_a, s0, 2'd2, sym_a, sym_a);
    write_rule(slot[2], 1'b1, s0, 1'b0, sym_b, sym_a, s1, 2'd0, 8'($urandom), 8'($urandom));
    write_rule(slot[3], 1'b1, s1, 1'b0, sym_b, sym_a, s1, 2'd0, 8'($urandom), 8'($urandom));
    write_rule(slot[4], 1'b1, s1, 1'b1, 8'($urandom), cfg_bottom, cfg_accept, 2'd0,
               8'($urandom), 8'($urandom));
    if ($urandom_range(1)) write_rule(5'($urandom), 1'b1, s0, 1'b1, 8'($urandom), cfg_bottom,
                                      cfg_accept, 2'd0, 8'($urandom), 8'($urandom));
  endtask

  task automatic run_random(int in_pct, int out_pct, int count);
    int first;
    int n;
    int m;
    bit [7:0] sym_a;
    bit [7:0] sym_b;
    first = items_sent;
    idle_in_pct = in_pct;
    idle_out_pct = out_pct;
    while (items_sent - first < count) begin
      if ($urandom_range(3) == 0) reconfigure();
      program_balanced(sym_a, sym_b);
      repeat ($urandom_range(4, 10)) begin
        if (items_sent - first >= count) break;
        case ($urandom_range(9))
          0: begin
            if ($urandom_range(1)) send(random_request(2'($urandom)));
            else send(random_request(ACT_WRITE));
          end
          8, 9: begin
            n = $urandom_range(0, 6);
            m = n + $urandom_range(0, 2) - 1;
            for (int i = 0; i < n; i++) send_symbol(sym_a);
            for (int i = 0; i < m; i++)
              send_symbol($urandom_range(4) == 0 ? pick8() : sym_b);
            send_end();
          end
          default: begin
            n = ($urandom_range(14) == 0) ? $urandom_range(30, 66) : $urandom_range(0, 8);
            for (int i = 0; i < n; i++) send_symbol(sym_a);
            for (int i = 0; i < n; i++) send_symbol(sym_b);
            send_end();
          end
        endcase
      end
    end
    wait_idle();
  endtask

  task automatic test_backpressure();
    idle_in_pct = 0;
    idle_out_pct = 0;
    hold_left = 400;
    repeat (30) send(random_request($urandom_range(1) ? ACT_SYMBOL : ACT_END));
    wait_idle();
  endtask

  initial begin
    pda_fresh = 1'b1;
    load_run();
    pda_fresh = 1'b1;
    for (int i = 0; i < SLOTS; i++) rules[i] = '{default: 0};
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    run_random(34, 76, 430);
    test_backpressure();
    run_random(76, 34, 430);
    run_random(0, 0, 430);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
+incdir+rtl
rtl/tdpr_pkg.sv
rtl/tdpr_ram.sv
rtl/tdpr_keys.sv
rtl/table_driven_pushdown_recognizer.sv
verif/table_driven_pushdown_recognizer_tb.sv
